// ===== sv/lbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_pkg: shared definitions for the LED bounce scanner
// Reset values, register indexes, operation codes and sequencer types.
// ----------------------------------------------------------------------------
package lbs_pkg;

  // Default sizing of the scanner.
  localparam int MAX_WIDTH_DEF       = 15;
  localparam int PROFILE_ENTRIES_DEF = 8;

  // Reset values of the configuration registers and of the centre.
  localparam logic [7:0] STRIP_LENGTH_RST  = 8'd60;
  localparam logic [3:0] SCANNER_WIDTH_RST = 4'd5;
  localparam logic [7:0] CENTRE_RST        = 8'(SCANNER_WIDTH_RST / 2);

  // The scaling divider retires one quotient bit per cycle.
  localparam int DIV_STEPS = 16;

  // Configuration register indexes.
  localparam logic [7:0] CFG_STRIP_LENGTH  = 8'd0;
  localparam logic [7:0] CFG_SCANNER_WIDTH = 8'd1;
  localparam logic [7:0] CFG_PROFILE_MULT  = 8'd2;
  localparam logic [7:0] CFG_PROFILE_DIV   = 8'd3;

  // Operation codes of an input transaction.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_TRAIL,
    ST_CLEAR,
    ST_WIN
  } state_t;

  // Colour channel being scaled.
  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_t;

endpackage

// ===== sv/led_bounce_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_bounce_scanner: bouncing symmetric window on an RGB strip
// A start transaction scales its colour by the brightness profile and draws
// the window; a tick transaction moves the window one step and redraws it.
// ----------------------------------------------------------------------------
// A start transaction scales its colour for every slot of the window: each
// slot and colour channel goes through an 8x8 multiply and a shared
// restoring divider, one quotient bit per cycle. The window then goes out
// at one pixel per cycle while the result side keeps up. A tick
// transaction steps the centre as it is accepted and then delivers the
// trailing clear and the window, width + 1
// results, or a single clear-whole-strip result when a finite run ends. The
// input side is ready only when the previous transaction has been fully
// handed to the output register; the output register holds the final result
// while the next transaction is taken. Configuration writes are taken every
// cycle and must only be issued while the block is idle.
module led_bounce_scanner #(
  parameter int MAX_WIDTH       = lbs_pkg::MAX_WIDTH_DEF,
  parameter int PROFILE_ENTRIES = lbs_pkg::PROFILE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_operation,
  input  logic [7:0]        in_red,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_blue,
  input  logic signed [7:0] in_run_count,
  // Result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_clear_all,
  output logic [7:0]        out_led_index,
  output logic [7:0]        out_red_out,
  output logic [7:0]        out_green_out,
  output logic [7:0]        out_blue_out,
  output logic              out_scan_active,
  output logic              out_last,
  // Configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [63:0]       cfg_data
);
  import lbs_pkg::*;

  localparam int SLOTS  = MAX_WIDTH / 2 + 1;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
  localparam logic [4:0] SLOTS_M1 = 5'(SLOTS - 1);
  localparam logic [4:0] MAXW5    = 5'(MAX_WIDTH);
  localparam logic [4:0] PE_LAST  = 5'(PROFILE_ENTRIES - 1);
  localparam logic [3:0] DIV_LAST = 4'(DIV_STEPS - 1);

  // Registers
  state_t             state_r, state_nxt;
  logic [7:0]         strip_len_r;
  logic [3:0]         swidth_r;
  logic [63:0]        mult_r, divs_r;
  logic [7:0]         centre_r, centre_nxt;
  logic               up_r, up_nxt;
  logic signed [7:0]  runs_r, runs_nxt;
  logic [23:0]        slot_r [SLOTS];
  logic [23:0]        col_r, col_nxt;
  logic [SLOT_W-1:0]  k_r, k_nxt;
  chan_t              ch_r, ch_nxt;
  logic [3:0]         step_r, step_nxt;
  logic [15:0]        work_r, work_nxt;
  logic [7:0]         rem_r, rem_nxt;
  logic [7:0]         trail_r, trail_nxt;
  logic [3:0]         p_r, p_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_clear_r, out_clear_nxt;
  logic [7:0]         out_idx_r, out_idx_nxt;
  logic [23:0]        out_rgb_r, out_rgb_nxt;
  logic               out_active_r, out_active_nxt;
  logic               out_last_r, out_last_nxt;

  // Control strobes
  logic accept, out_free, out_load, slot_we;

  // Effective window geometry.
  logic [3:0] w_eff, w_last;
  logic [7:0] half;
  always_comb begin
    w_eff  = ({1'b0, swidth_r} > MAXW5) ? MAXW5[3:0] : swidth_r;
    w_last = w_eff - 4'd1;
    half   = {5'd0, w_eff[3:1]};
  end

  // Tick step: trailing pixel, new centre, direction and run count.
  logic [7:0]        top, trail, loc_new;
  logic              up_new, run_end, tick_cont;
  logic signed [7:0] runs_new;
  always_comb begin
    top     = strip_len_r - 8'd1 - half;
    trail   = up_r ? (centre_r - half) : (centre_r + half);
    loc_new = centre_r;
    up_new  = up_r;
    if (up_r) begin
      if (centre_r < top) loc_new = centre_r + 8'd1;
      if (loc_new == top) up_new = 1'b0;
    end else begin
      if (centre_r > half) loc_new = centre_r - 8'd1;
      if (loc_new == half) up_new = 1'b1;
    end
    run_end   = (runs_r > 8'sd0) && (loc_new == half);
    runs_new  = run_end ? (runs_r - 8'sd1) : runs_r;
    tick_cont = !run_end || (runs_r > 8'sd1);
  end

  // Profile bytes for the slot being scaled; entries past the profile clamp.
  logic [4:0] k_clamp;
  logic [7:0] mul_byte, div_byte, col_sel;
  always_comb begin
    k_clamp  = (5'(k_r) > PE_LAST) ? PE_LAST : 5'(k_r);
    mul_byte = (k_clamp < 5'd8) ? mult_r[{k_clamp[2:0], 3'b000} +: 8] : 8'd0;
    div_byte = (k_clamp < 5'd8) ? divs_r[{k_clamp[2:0], 3'b000} +: 8] : 8'd0;
    case (ch_r)
      CH_RED:   col_sel = col_r[23:16];
      CH_GREEN: col_sel = col_r[15:8];
      CH_BLUE:  col_sel = col_r[7:0];
      default:  col_sel = 8'd0;
    endcase
  end

  // Shared restoring divider step: one quotient bit per cycle.
  logic [8:0]  div_shift;
  logic        div_ge;
  logic [7:0]  div_rem;
  logic [15:0] div_work;
  logic [7:0]  div_q;
  always_comb begin
    div_shift = {rem_r, work_r[15]};
    div_ge    = div_shift >= {1'b0, div_byte};
    div_rem   = div_ge ? 8'(div_shift - {1'b0, div_byte}) : div_shift[7:0];
    div_work  = {work_r[14:0], div_ge};
    div_q     = (div_byte == 8'd0) ? 8'd0 : div_work[7:0];
  end

  // Window slot for the pixel being written, mirrored about the centre.
  logic [3:0]        p_mirror, k_min;
  logic [4:0]        k_win;
  logic [SLOT_W-1:0] slot_idx;
  always_comb begin
    p_mirror = w_last - p_r;
    k_min    = (p_r < p_mirror) ? p_r : p_mirror;
    if (!w_eff[0] && (k_min == (w_eff[3:1] - 4'd1))) k_min = {1'b0, w_eff[3:1]};
    k_win    = ({1'b0, k_min} > SLOTS_M1) ? SLOTS_M1 : {1'b0, k_min};
    slot_idx = k_win[SLOT_W-1:0];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_START) state_nxt = ST_MUL;
          else state_nxt = tick_cont ? ST_TRAIL : ST_CLEAR;
        end
      end
      ST_MUL: state_nxt = ST_DIV;
      ST_DIV: begin
        if (step_r == DIV_LAST) begin
          if (k_r == SLOT_LAST && ch_r == CH_BLUE)
            state_nxt = (w_eff == 4'd0) ? ST_IDLE : ST_WIN;
          else
            state_nxt = ST_MUL;
        end
      end
      ST_TRAIL: begin
        if (out_free) state_nxt = (w_eff == 4'd0) ? ST_IDLE : ST_WIN;
      end
      ST_CLEAR: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_WIN: begin
        if (out_free && p_r == w_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    cfg_ready = 1'b1;
    accept    = in_valid && in_ready;
    out_free  = !out_valid_r || out_ready;
    out_load  = out_free &&
                (state_r == ST_TRAIL || state_r == ST_CLEAR || state_r == ST_WIN);
    slot_we   = (state_r == ST_DIV) && (step_r == DIV_LAST);
  end

  // Datapath next values.
  always_comb begin
    centre_nxt     = centre_r;
    up_nxt         = up_r;
    runs_nxt       = runs_r;
    col_nxt        = col_r;
    k_nxt          = k_r;
    ch_nxt         = ch_r;
    step_nxt       = step_r;
    work_nxt       = work_r;
    rem_nxt        = rem_r;
    trail_nxt      = trail_r;
    p_nxt          = p_r;
    out_valid_nxt  = out_valid_r;
    out_clear_nxt  = out_clear_r;
    out_idx_nxt    = out_idx_r;
    out_rgb_nxt    = out_rgb_r;
    out_active_nxt = out_active_r;
    out_last_nxt   = out_last_r;

    // Capture an input transaction.
    if (accept) begin
      col_nxt = {in_red, in_green, in_blue};
      p_nxt   = 4'd0;
      if (in_operation == OP_START) begin
        runs_nxt = in_run_count;
        up_nxt   = 1'b1;
        k_nxt    = '0;
        ch_nxt   = CH_RED;
      end else begin
        centre_nxt = loc_new;
        up_nxt     = up_new;
        runs_nxt   = runs_new;
        trail_nxt  = trail;
      end
    end

    // Scaling: multiply, then divide bit by bit.
    if (state_r == ST_MUL) begin
      work_nxt = {8'd0, col_sel} * {8'd0, mul_byte};
      rem_nxt  = 8'd0;
      step_nxt = 4'd0;
    end
    if (state_r == ST_DIV) begin
      work_nxt = div_work;
      rem_nxt  = div_rem;
      step_nxt = step_r + 4'd1;
      if (step_r == DIV_LAST) begin
        case (ch_r)
          CH_RED:   ch_nxt = CH_GREEN;
          CH_GREEN: ch_nxt = CH_BLUE;
          default: begin
            ch_nxt = CH_RED;
            if (k_r != SLOT_LAST) k_nxt = k_r + SLOT_W'(1);
          end
        endcase
      end
    end

    // Result register.
    if (out_load) begin
      out_valid_nxt = 1'b1;
      case (state_r)
        ST_TRAIL: begin
          out_clear_nxt  = 1'b0;
          out_idx_nxt    = trail_r;
          out_rgb_nxt    = 24'd0;
          out_active_nxt = 1'b1;
          out_last_nxt   = (w_eff == 4'd0);
        end
        ST_CLEAR: begin
          out_clear_nxt  = 1'b1;
          out_idx_nxt    = 8'd0;
          out_rgb_nxt    = 24'd0;
          out_active_nxt = 1'b0;
          out_last_nxt   = 1'b1;
        end
        default: begin
          out_clear_nxt  = 1'b0;
          out_idx_nxt    = centre_r - half + {4'd0, p_r};
          out_rgb_nxt    = slot_r[slot_idx];
          out_active_nxt = 1'b1;
          out_last_nxt   = (p_r == w_last);
          p_nxt          = p_r + 4'd1;
        end
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      strip_len_r <= STRIP_LENGTH_RST;
      swidth_r    <= SCANNER_WIDTH_RST;
      mult_r      <= 64'd0;
      divs_r      <= 64'd0;
      centre_r    <= CENTRE_RST;
      up_r        <= 1'b1;
      runs_r      <= 8'sd0;
      k_r         <= '0;
      ch_r        <= CH_RED;
      step_r      <= 4'd0;
      p_r         <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      centre_r <= centre_nxt;
      up_r     <= up_nxt;
      runs_r   <= runs_nxt;
      k_r      <= k_nxt;
      ch_r     <= ch_nxt;
      step_r   <= step_nxt;
      p_r      <= p_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STRIP_LENGTH:  strip_len_r <= cfg_data[7:0];
          CFG_SCANNER_WIDTH: swidth_r    <= cfg_data[3:0];
          CFG_PROFILE_MULT:  mult_r      <= cfg_data;
          CFG_PROFILE_DIV:   divs_r      <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Scaled colour slots, written one channel at a time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) slot_r[i] <= 24'd0;
    end else if (slot_we) begin
      case (ch_r)
        CH_RED:   slot_r[k_r][23:16] <= div_q;
        CH_GREEN: slot_r[k_r][15:8]  <= div_q;
        default:  slot_r[k_r][7:0]   <= div_q;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    col_r        <= col_nxt;
    work_r       <= work_nxt;
    rem_r        <= rem_nxt;
    trail_r      <= trail_nxt;
    out_clear_r  <= out_clear_nxt;
    out_idx_r    <= out_idx_nxt;
    out_rgb_r    <= out_rgb_nxt;
    out_active_r <= out_active_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Result ports.
  assign out_valid       = out_valid_r;
  assign out_clear_all   = out_clear_r;
  assign out_led_index   = out_idx_r;
  assign out_red_out     = out_rgb_r[23:16];
  assign out_green_out   = out_rgb_r[15:8];
  assign out_blue_out    = out_rgb_r[7:0];
  assign out_scan_active = out_active_r;
  assign out_last        = out_last_r;

endmodule

// ===== sv/lbs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_checker: port-level checks for the LED bounce scanner
// Watches the top-level ports and flags results that break the block's rules.
// ----------------------------------------------------------------------------
module lbs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_clear_all,
  input logic [7:0] out_led_index,
  input logic [7:0] out_red_out,
  input logic [7:0] out_green_out,
  input logic [7:0] out_blue_out,
  input logic       out_scan_active,
  input logic       out_last
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_led_index) &&
      $stable(out_red_out) && $stable(out_green_out) && $stable(out_blue_out) &&
      $stable(out_clear_all) && $stable(out_last))
    else $error("result payload changed while stalled");

  // A strip clear is the only and final result, black, and ends the scan.
  a_clear_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clear_all |-> out_last && !out_scan_active &&
      out_led_index == 8'd0 && out_red_out == 8'd0 &&
      out_green_out == 8'd0 && out_blue_out == 8'd0)
    else $error("malformed strip clear result");

  // Every pixel write belongs to a scan that is still running.
  a_pixel_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_clear_all |-> out_scan_active)
    else $error("pixel write with scan inactive");

  // Every accepted input transaction leaves the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted transaction");

endmodule

bind led_bounce_scanner lbs_checker u_lbs_checker (.*);
